/* sv/dts_pkg.sv */
// shared types, codes and constants for the duration text parser
`timescale 1ns / 1ps

package dts_pkg;

  // one character transfer
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_t;

  // one result transfer
  typedef struct packed {
    logic [30:0] seconds;
    logic [1:0]  status;
  } result_t;

  // control passed from the parse stage to the accumulate stage
  typedef struct packed {
    logic       last;
    logic       add;
    logic [1:0] status;
  } unit_ctl_t;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_MONTHS   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // parse phases
  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_NUMBER = 2'd1;
  localparam logic [1:0] PH_DATE   = 2'd2;
  localparam logic [1:0] PH_TIME   = 2'd3;

  // unit ranks, in the order they must appear; a week count must stand alone
  localparam logic [2:0] RANK_NONE   = 3'd0;
  localparam logic [2:0] RANK_YEAR   = 3'd1;
  localparam logic [2:0] RANK_MONTH  = 3'd2;
  localparam logic [2:0] RANK_DAY    = 3'd3;
  localparam logic [2:0] RANK_HOUR   = 3'd4;
  localparam logic [2:0] RANK_MINUTE = 3'd5;
  localparam logic [2:0] RANK_SECOND = 3'd6;
  localparam logic [2:0] RANK_WEEK   = 3'd7;

  // seconds per unit
  localparam int unsigned MULT_W = 25;
  localparam logic [MULT_W-1:0] SEC_YEAR   = 25'd31536000;
  localparam logic [MULT_W-1:0] SEC_WEEK   = 25'd604800;
  localparam logic [MULT_W-1:0] SEC_DAY    = 25'd86400;
  localparam logic [MULT_W-1:0] SEC_HOUR   = 25'd3600;
  localparam logic [MULT_W-1:0] SEC_MINUTE = 25'd60;
  localparam logic [MULT_W-1:0] SEC_SECOND = 25'd1;

  // character codes
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_Y = 8'h59;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_W = 8'h57;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_S = 8'h53;

  // merge a new error into the current one: invalid over months over overflow
  function automatic logic [1:0] raise_status(input logic [1:0] cur, input logic [1:0] code);
    logic [1:0] r;
    r = cur;
    if (cur == ST_OK || code == ST_INVALID || (code == ST_MONTHS && cur == ST_OVERFLOW)) begin
      r = code;
    end
    return r;
  endfunction

endpackage

/* sv/duration_text_to_seconds.sv */
// Duration text parser: one character per transfer in, one result per string out.
// The char channel (char_valid, char_stall, char_data) carries one ASCII
// character and a last_char flag per transfer. After the transfer that carries
// last_char, one transfer on the result channel (result_valid, result_stall,
// result_data) gives the total in seconds and a status: ok, invalid format,
// months unsupported or overflow. Seconds are zero when the status is not ok.
// Accepted forms are a bare decimal number, PnW and PnYnMnDTnHnMnS.
// Throughput is one character per cycle: the parse stage register hands its
// transfer to the accumulate stage in the next cycle, so a character is taken
// every cycle unless a final character waits behind a stalled result.
// The final character's outcome passes through the parse stage register and then
// the result register, and waits in the parse stage register while an earlier
// result is stalled.
// While the receiver stalls a waiting result, characters of the next string
// keep flowing until its final character waits in the parse stage register;
// char_stall then rises until the result is taken.
// Reset (rst, synchronous) empties both stages and returns the parser to the
// start of a string. SECONDS_WIDTH sets the internal total width; totals above
// 2^(SECONDS_WIDTH-1)-1 give the overflow status.
`timescale 1ns / 1ps

module duration_text_to_seconds #(
  parameter int SECONDS_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  dts_pkg::char_t     char_data,
  output logic               result_valid,
  input  logic               result_stall,
  output dts_pkg::result_t   result_data
);

  logic                     part_valid;
  dts_pkg::unit_ctl_t       part_ctl;
  logic [SECONDS_WIDTH-2:0] part;
  logic                     take;

  // character parse and unit scaling
  dts_parse #(
    .SECONDS_WIDTH (SECONDS_WIDTH)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data),
    .take       (take),
    .part_valid (part_valid),
    .part_ctl   (part_ctl),
    .part       (part)
  );

  // running total and result register
  dts_accum #(
    .SECONDS_WIDTH (SECONDS_WIDTH)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .part_valid   (part_valid),
    .part_ctl     (part_ctl),
    .part         (part),
    .take         (take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

/* sv/dts_parse.sv */
// character parse stage: phase, unit order, digit value and scaled part
`timescale 1ns / 1ps

module dts_parse #(
  parameter int SECONDS_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       char_valid,
  output logic                       char_stall,
  input  dts_pkg::char_t             char_data,
  input  logic                       take,
  output logic                       part_valid,
  output dts_pkg::unit_ctl_t         part_ctl,
  output logic [SECONDS_WIDTH-2:0]   part
);

  localparam int VW = SECONDS_WIDTH - 1;
  localparam logic [VW-1:0] LIMIT = '1;
  localparam logic [VW-1:0] LIM_YEAR   = VW'(LIMIT / dts_pkg::SEC_YEAR);
  localparam logic [VW-1:0] LIM_WEEK   = VW'(LIMIT / dts_pkg::SEC_WEEK);
  localparam logic [VW-1:0] LIM_DAY    = VW'(LIMIT / dts_pkg::SEC_DAY);
  localparam logic [VW-1:0] LIM_HOUR   = VW'(LIMIT / dts_pkg::SEC_HOUR);
  localparam logic [VW-1:0] LIM_MINUTE = VW'(LIMIT / dts_pkg::SEC_MINUTE);

  logic [1:0]    phase, phase_next;
  logic [2:0]    rank, rank_next;
  logic [VW-1:0] digit_value, digit_value_next;
  logic          digits_seen, digits_seen_next;
  logic [1:0]    err, err_next;

  logic          ready;
  logic          accept;
  logic [7:0]    c;
  logic          is_digit;
  logic [VW+3:0] dv_ext;
  logic          dv_ovf;
  logic          unit_go;
  logic [2:0]    unit_rank;
  logic [dts_pkg::MULT_W-1:0] mult_sel;
  logic [VW-1:0] lim_sel;
  logic [VW+dts_pkg::MULT_W-1:0] prod_full;
  logic          add_next;
  logic [VW-1:0] part_next;

  // handshake with the accumulate stage
  assign ready      = !part_valid || take;
  assign char_stall = !ready;
  assign accept     = char_valid && ready;

  // digit step: value * 10 + digit, checked against the limit
  assign c        = char_data.char_code;
  assign is_digit = (c >= dts_pkg::CH_0) && (c <= dts_pkg::CH_9);
  assign dv_ext   = ((VW+4)'(digit_value) << 3) + ((VW+4)'(digit_value) << 1)
                  + (VW+4)'(c[3:0]);
  assign dv_ovf   = dv_ext > (VW+4)'(LIMIT);

  // seconds per unit and the largest count that still fits
  always_comb begin
    case (unit_rank)
      dts_pkg::RANK_YEAR: begin
        mult_sel = dts_pkg::SEC_YEAR;
        lim_sel  = LIM_YEAR;
      end
      dts_pkg::RANK_WEEK: begin
        mult_sel = dts_pkg::SEC_WEEK;
        lim_sel  = LIM_WEEK;
      end
      dts_pkg::RANK_DAY: begin
        mult_sel = dts_pkg::SEC_DAY;
        lim_sel  = LIM_DAY;
      end
      dts_pkg::RANK_HOUR: begin
        mult_sel = dts_pkg::SEC_HOUR;
        lim_sel  = LIM_HOUR;
      end
      dts_pkg::RANK_MINUTE: begin
        mult_sel = dts_pkg::SEC_MINUTE;
        lim_sel  = LIM_MINUTE;
      end
      dts_pkg::RANK_SECOND: begin
        mult_sel = dts_pkg::SEC_SECOND;
        lim_sel  = LIMIT;
      end
      default: begin
        mult_sel = '0;
        lim_sel  = LIMIT;
      end
    endcase
  end

  assign prod_full = (VW+dts_pkg::MULT_W)'(digit_value) * (VW+dts_pkg::MULT_W)'(mult_sel);

  // next parse state for one character
  always_comb begin
    phase_next       = phase;
    rank_next        = rank;
    digit_value_next = digit_value;
    digits_seen_next = digits_seen;
    err_next         = err;
    unit_go          = 1'b0;
    unit_rank        = dts_pkg::RANK_NONE;
    add_next         = 1'b0;
    part_next        = '0;

    if (err != dts_pkg::ST_INVALID) begin
      if (rank == dts_pkg::RANK_WEEK) begin
        err_next = dts_pkg::raise_status(err, dts_pkg::ST_INVALID);
      end else if (is_digit) begin
        if (phase == dts_pkg::PH_START) begin
          phase_next = dts_pkg::PH_NUMBER;
        end
        if (dv_ovf) begin
          err_next         = dts_pkg::raise_status(err, dts_pkg::ST_OVERFLOW);
          digit_value_next = LIMIT;
        end else begin
          digit_value_next = dv_ext[VW-1:0];
        end
        digits_seen_next = 1'b1;
      end else begin
        case (phase)
          dts_pkg::PH_START: begin
            if (c == dts_pkg::CH_P) begin
              phase_next = dts_pkg::PH_DATE;
            end else begin
              err_next = dts_pkg::raise_status(err, dts_pkg::ST_INVALID);
            end
          end
          dts_pkg::PH_DATE: begin
            case (c)
              dts_pkg::CH_T: begin
                if (digits_seen) begin
                  err_next = dts_pkg::raise_status(err, dts_pkg::ST_INVALID);
                end else begin
                  phase_next = dts_pkg::PH_TIME;
                end
              end
              dts_pkg::CH_Y: begin
                unit_go   = 1'b1;
                unit_rank = dts_pkg::RANK_YEAR;
              end
              dts_pkg::CH_M: begin
                unit_go   = 1'b1;
                unit_rank = dts_pkg::RANK_MONTH;
              end
              dts_pkg::CH_D: begin
                unit_go   = 1'b1;
                unit_rank = dts_pkg::RANK_DAY;
              end
              dts_pkg::CH_W: begin
                unit_go   = 1'b1;
                unit_rank = dts_pkg::RANK_WEEK;
              end
              default: begin
                err_next = dts_pkg::raise_status(err, dts_pkg::ST_INVALID);
              end
            endcase
          end
          dts_pkg::PH_TIME: begin
            case (c)
              dts_pkg::CH_H: begin
                unit_go   = 1'b1;
                unit_rank = dts_pkg::RANK_HOUR;
              end
              dts_pkg::CH_M: begin
                unit_go   = 1'b1;
                unit_rank = dts_pkg::RANK_MINUTE;
              end
              dts_pkg::CH_S: begin
                unit_go   = 1'b1;
                unit_rank = dts_pkg::RANK_SECOND;
              end
              default: begin
                err_next = dts_pkg::raise_status(err, dts_pkg::ST_INVALID);
              end
            endcase
          end
          default: begin
            err_next = dts_pkg::raise_status(err, dts_pkg::ST_INVALID);
          end
        endcase
      end
    end

    // unit designator: order check, then scaled part or month check
    if (unit_go) begin
      if (!digits_seen || unit_rank <= rank ||
          (unit_rank == dts_pkg::RANK_WEEK && rank != dts_pkg::RANK_NONE)) begin
        err_next = dts_pkg::raise_status(err, dts_pkg::ST_INVALID);
      end else begin
        if (unit_rank == dts_pkg::RANK_MONTH) begin
          if (digit_value != '0) begin
            err_next = dts_pkg::raise_status(err, dts_pkg::ST_MONTHS);
          end
        end else begin
          add_next = 1'b1;
          if (digit_value > lim_sel) begin
            err_next  = dts_pkg::raise_status(err, dts_pkg::ST_OVERFLOW);
            part_next = LIMIT;
          end else begin
            part_next = prod_full[VW-1:0];
          end
        end
        rank_next        = unit_rank;
        digit_value_next = '0;
        digits_seen_next = 1'b0;
      end
    end

    // end of string: bare number, or check for a dangling count
    if (char_data.last_char && err_next != dts_pkg::ST_INVALID) begin
      if (phase_next == dts_pkg::PH_NUMBER) begin
        add_next  = 1'b1;
        part_next = digit_value_next;
      end else if (phase_next == dts_pkg::PH_START || digits_seen_next) begin
        err_next = dts_pkg::raise_status(err_next, dts_pkg::ST_INVALID);
      end
    end
  end

  // parse state, cleared after the final character
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= dts_pkg::PH_START;
      rank        <= dts_pkg::RANK_NONE;
      digit_value <= '0;
      digits_seen <= 1'b0;
      err         <= dts_pkg::ST_OK;
    end else if (accept) begin
      if (char_data.last_char) begin
        phase       <= dts_pkg::PH_START;
        rank        <= dts_pkg::RANK_NONE;
        digit_value <= '0;
        digits_seen <= 1'b0;
        err         <= dts_pkg::ST_OK;
      end else begin
        phase       <= phase_next;
        rank        <= rank_next;
        digit_value <= digit_value_next;
        digits_seen <= digits_seen_next;
        err         <= err_next;
      end
    end
  end

  // stage register toward the accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      part_valid <= 1'b0;
      part_ctl   <= '0;
    end else if (accept) begin
      part_valid      <= 1'b1;
      part_ctl.last   <= char_data.last_char;
      part_ctl.add    <= add_next;
      part_ctl.status <= err_next;
    end else if (take) begin
      part_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      part <= part_next;
    end
  end

endmodule

/* sv/dts_accum.sv */
// accumulate stage: running total, overflow and the result register
`timescale 1ns / 1ps

module dts_accum #(
  parameter int SECONDS_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     part_valid,
  input  dts_pkg::unit_ctl_t       part_ctl,
  input  logic [SECONDS_WIDTH-2:0] part,
  output logic                     take,
  output logic                     result_valid,
  input  logic                     result_stall,
  output dts_pkg::result_t         result_data
);

  localparam int VW = SECONDS_WIDTH - 1;
  localparam logic [VW-1:0] LIMIT = '1;

  logic [VW-1:0] total, total_next;
  logic          ovf, ovf_next;
  logic [VW:0]   sum;
  logic          sum_ovf;
  logic [1:0]    status_fin;

  // a non-final transfer is always taken; the final one needs the result slot
  assign take = part_valid && (!part_ctl.last || !result_valid || !result_stall);

  // both operands stay at or below the limit, so the top bit flags overflow
  assign sum     = {1'b0, total} + {1'b0, part};
  assign sum_ovf = sum[VW];

  always_comb begin
    total_next = total;
    ovf_next   = ovf;
    if (part_ctl.add) begin
      if (sum_ovf) begin
        total_next = LIMIT;
        ovf_next   = 1'b1;
      end else begin
        total_next = sum[VW-1:0];
      end
    end
  end

  assign status_fin = ovf_next ? dts_pkg::raise_status(part_ctl.status, dts_pkg::ST_OVERFLOW)
                               : part_ctl.status;

  // running total, cleared after each result
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      ovf   <= 1'b0;
    end else if (take) begin
      if (part_ctl.last) begin
        total <= '0;
        ovf   <= 1'b0;
      end else begin
        total <= total_next;
        ovf   <= ovf_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take && part_ctl.last) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && part_ctl.last) begin
      result_data.status  <= status_fin;
      result_data.seconds <= (status_fin == dts_pkg::ST_OK) ? 31'(total_next) : '0;
    end
  end

`ifndef ASSERT_OFF
  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.status != dts_pkg::ST_OK |-> result_data.seconds == '0)
    else $error("nonzero seconds with an error status");

  a_final_loads_result: assert property (@(posedge clk) disable iff (rst)
    take && part_ctl.last |=> result_valid)
    else $error("final transfer did not load the result register");

  a_total_cleared: assert property (@(posedge clk) disable iff (rst)
    take && part_ctl.last |=> total == '0 && !ovf)
    else $error("running total not cleared after a result");

  a_result_drains: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !(take && part_ctl.last) |=> !result_valid)
    else $error("result kept after its transfer");
`endif

endmodule

/* bench/tb_duration_text_to_seconds.sv */
// self-checking testbench for the duration text parser
`timescale 1ns / 1ps

module tb_duration_text_to_seconds;

  localparam longint unsigned SEC_MAX = (64'd1 << 31) - 1;
  localparam int RANDOM_CHARS = 950;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic char_valid = 1'b0;
  logic char_stall;
  dts_pkg::char_t char_data = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  dts_pkg::result_t result_data;

  duration_text_to_seconds DUT (
    .clk(clk),
    .rst(rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_data(char_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data(result_data)
  );

  // clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dts_pkg::char_t pending_chars[$];
  dts_pkg::result_t expected_results[$];
  bit [7:0] draft[$];
  int errors = 0;
  int results_taken = 0;

  // parser state mirrored by the predictor
  logic [1:0] scan_phase = dts_pkg::PH_START;
  logic [2:0] scan_rank = dts_pkg::RANK_NONE;
  longint unsigned scan_number = 0;
  bit scan_digits = 1'b0;
  longint unsigned scan_total = 0;
  logic [1:0] scan_status = dts_pkg::ST_OK;

  // invalid beats months, months beats overflow
  task automatic note_error(input logic [1:0] code);
    if (scan_status == dts_pkg::ST_OK || code == dts_pkg::ST_INVALID ||
        (code == dts_pkg::ST_MONTHS && scan_status == dts_pkg::ST_OVERFLOW)) begin
      scan_status = code;
    end
  endtask

  // add number * seconds_per_unit to the total, saturating
  task automatic add_scaled(input longint unsigned per_unit);
    longint unsigned part;
    if (scan_number != 0 && scan_number > SEC_MAX / per_unit) begin
      note_error(dts_pkg::ST_OVERFLOW);
      part = SEC_MAX;
    end else begin
      part = scan_number * per_unit;
    end
    if (part > SEC_MAX - scan_total) begin
      note_error(dts_pkg::ST_OVERFLOW);
      scan_total = SEC_MAX;
    end else begin
      scan_total = scan_total + part;
    end
  endtask

  task automatic close_unit(input logic [2:0] rank);
    longint unsigned per_unit;
    if (!scan_digits || rank <= scan_rank ||
        (rank == dts_pkg::RANK_WEEK && scan_rank != dts_pkg::RANK_NONE)) begin
      note_error(dts_pkg::ST_INVALID);
      return;
    end
    case (rank)
      dts_pkg::RANK_YEAR:   per_unit = 64'd365 * 24 * 3600;
      dts_pkg::RANK_DAY:    per_unit = 64'd24 * 3600;
      dts_pkg::RANK_HOUR:   per_unit = 64'd3600;
      dts_pkg::RANK_MINUTE: per_unit = 64'd60;
      dts_pkg::RANK_SECOND: per_unit = 64'd1;
      default:              per_unit = 64'd7 * 24 * 3600;
    endcase
    if (rank == dts_pkg::RANK_MONTH) begin
      if (scan_number != 0) note_error(dts_pkg::ST_MONTHS);
    end else begin
      add_scaled(per_unit);
    end
    scan_rank = rank;
    scan_number = 0;
    scan_digits = 1'b0;
  endtask

  task automatic scan_char(input logic [7:0] c);
    longint unsigned d;
    if (scan_status == dts_pkg::ST_INVALID) return;
    // nothing may follow a week count
    if (scan_rank == dts_pkg::RANK_WEEK) begin
      note_error(dts_pkg::ST_INVALID);
      return;
    end
    if (c >= dts_pkg::CH_0 && c <= dts_pkg::CH_9) begin
      d = c - dts_pkg::CH_0;
      if (scan_phase == dts_pkg::PH_START) scan_phase = dts_pkg::PH_NUMBER;
      if (scan_number > (SEC_MAX - d) / 10) begin
        note_error(dts_pkg::ST_OVERFLOW);
        scan_number = SEC_MAX;
      end else begin
        scan_number = scan_number * 10 + d;
      end
      scan_digits = 1'b1;
      return;
    end
    case (scan_phase)
      dts_pkg::PH_START: begin
        if (c == dts_pkg::CH_P) scan_phase = dts_pkg::PH_DATE;
        else note_error(dts_pkg::ST_INVALID);
      end
      dts_pkg::PH_DATE: begin
        case (c)
          dts_pkg::CH_T: begin
            if (scan_digits) note_error(dts_pkg::ST_INVALID);
            else scan_phase = dts_pkg::PH_TIME;
          end
          dts_pkg::CH_Y: close_unit(dts_pkg::RANK_YEAR);
          dts_pkg::CH_M: close_unit(dts_pkg::RANK_MONTH);
          dts_pkg::CH_D: close_unit(dts_pkg::RANK_DAY);
          dts_pkg::CH_W: close_unit(dts_pkg::RANK_WEEK);
          default: note_error(dts_pkg::ST_INVALID);
        endcase
      end
      dts_pkg::PH_TIME: begin
        case (c)
          dts_pkg::CH_H: close_unit(dts_pkg::RANK_HOUR);
          dts_pkg::CH_M: close_unit(dts_pkg::RANK_MINUTE);
          dts_pkg::CH_S: close_unit(dts_pkg::RANK_SECOND);
          default: note_error(dts_pkg::ST_INVALID);
        endcase
      end
      default: note_error(dts_pkg::ST_INVALID);
    endcase
  endtask

  // end of string: queue the expected result and start over
  task automatic close_string();
    dts_pkg::result_t r;
    if (scan_status != dts_pkg::ST_INVALID) begin
      if (scan_phase == dts_pkg::PH_NUMBER) scan_total = scan_number;
      else if (scan_phase == dts_pkg::PH_START || scan_digits) note_error(dts_pkg::ST_INVALID);
    end
    r.status = scan_status;
    r.seconds = (scan_status == dts_pkg::ST_OK) ? scan_total[30:0] : '0;
    expected_results.push_back(r);
    scan_phase = dts_pkg::PH_START;
    scan_rank = dts_pkg::RANK_NONE;
    scan_number = 0;
    scan_digits = 1'b0;
    scan_total = 0;
    scan_status = dts_pkg::ST_OK;
  endtask

  // string building
  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
  endtask

  task automatic put_number();
    int n;
    case ($urandom_range(0, 11))
      0, 1, 2, 3: put_text($sformatf("%0d", $urandom_range(0, 99)));
      4: put_text($sformatf("%0d", $urandom_range(0, 99999)));
      5: put_text($sformatf("%0d", $urandom_range(55, 75)));
      6: put_text($sformatf("%0d", $urandom_range(20000, 30000)));
      7: put_text($sformatf("%0d", $urandom));
      8: put_text($sformatf("00%0d", $urandom_range(0, 9)));
      9: put_text($sformatf("%0d", $urandom_range(2147483600, 2147483647)));
      default: begin
        n = $urandom_range(10, 13);
        for (int i = 0; i < n; i++) draft.push_back(8'(dts_pkg::CH_0 + $urandom_range(0, 9)));
      end
    endcase
  endtask

  task automatic put_unit(input string unit_char);
    if ($urandom_range(0, 1)) begin
      put_number();
      put_text(unit_char);
    end
  endtask

  // insert, drop, swap or replace one character
  task automatic damage_draft();
    string alphabet;
    int pos;
    bit [7:0] t;
    alphabet = "PTYMDWHS0123456789";
    pos = $urandom_range(0, draft.size() - 1);
    case ($urandom_range(0, 3))
      0: draft.insert(pos, 8'($urandom_range(0, 255)));
      1: if (draft.size() > 1) draft.delete(pos);
      2: begin
        if (pos + 1 < draft.size()) begin
          t = draft[pos];
          draft[pos] = draft[pos + 1];
          draft[pos + 1] = t;
        end
      end
      default: draft[pos] = alphabet[$urandom_range(0, alphabet.len() - 1)];
    endcase
  endtask

  task automatic commit_draft();
    dts_pkg::char_t c;
    for (int i = 0; i < draft.size(); i++) begin
      c.char_code = draft[i];
      c.last_char = (i == draft.size() - 1);
      pending_chars.push_back(c);
    end
    draft.delete();
  endtask

  task automatic add_directed(input string s);
    put_text(s);
    commit_draft();
  endtask

  task automatic build_random_string();
    string alphabet;
    alphabet = "PTYMDWHS0123456789+-pt ";
    case ($urandom_range(0, 19))
      // designator form
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
        put_text("P");
        put_unit("Y");
        if ($urandom_range(0, 1)) begin
          if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 1)) put_text("0");
            else put_text("00");
          end else begin
            put_number();
          end
          put_text("M");
        end
        put_unit("D");
        if ($urandom_range(0, 2) != 0) begin
          put_text("T");
          put_unit("H");
          put_unit("M");
          put_unit("S");
        end
        if ($urandom_range(0, 4) == 0) damage_draft();
      end
      // week form
      11, 12: begin
        put_text("P");
        put_number();
        put_text("W");
        if ($urandom_range(0, 4) == 0) draft.push_back(alphabet[$urandom_range(0, 17)]);
        if ($urandom_range(0, 5) == 0) damage_draft();
      end
      // bare seconds
      13, 14, 15: begin
        put_number();
        if ($urandom_range(0, 7) == 0) damage_draft();
      end
      // noise
      default: begin
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(0, 1)) draft.push_back(8'($urandom_range(0, 255)));
          else draft.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
        end
      end
    endcase
    commit_draft();
  endtask

  // sender: bursts of random length, random gaps between them
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (!char_valid || !char_stall) begin
      if (gap_left > 0 || pending_chars.size() == 0) begin
        if (gap_left > 0) gap_left--;
        char_valid <= 1'b0;
      end else begin
        char_data <= pending_chars.pop_front();
        char_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // receiver: stall pattern of its own, plus one long hold-off
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (!hold_done && results_taken >= 40) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        2: result_stall <= $urandom_range(0, 1);
        default: result_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // monitor: predict on each character transfer, check each result transfer
  always @(posedge clk) begin
    dts_pkg::result_t want;
    if (!rst) begin
      if (char_valid && !char_stall) begin
        scan_char(char_data.char_code);
        if (char_data.last_char) close_string();
      end
      if (result_valid && !result_stall) begin
        results_taken <= results_taken + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result seconds %0d status %0d", $time,
                   result_data.seconds, result_data.status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (result_data.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, result_data.status);
            errors++;
          end
          if (result_data.seconds !== want.seconds) begin
            $display("%0t: seconds expected %0d got %0d", $time, want.seconds,
                     result_data.seconds);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               idle_cycles, expected_results.size());
      $display("tb_duration_text_to_seconds: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    // empty designators, number extremes, weeks, months and precedence
    add_directed("P");
    add_directed("PT");
    add_directed("0");
    add_directed("2147483647");
    add_directed("2147483648");
    add_directed("P1W");
    add_directed("P1WT");
    add_directed("P0M");
    add_directed("P2Mx");
    add_directed("P69Y");
    add_directed("p");
    add_directed("PT1S");
    add_directed("P1DT");
    while (pending_chars.size() < RANDOM_CHARS) build_random_string();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_chars.size() != 0 || char_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("tb_duration_text_to_seconds: clean");
    end else begin
      $display("tb_duration_text_to_seconds: errors");
    end
    $finish;
  end

endmodule
